@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ hw/rtl/obhit_pkg.sv @@
// types and codes for the obstacle hit test unit
package obhit_pkg;

	// obstacle shape codes
	typedef enum logic [1:0] {
		SHAPE_WALL     = 2'd0,
		SHAPE_CIRCLE   = 2'd1,
		SHAPE_L        = 2'd2,
		SHAPE_CORRIDOR = 2'd3
	} shape_kind_t;

	// operation codes
	localparam logic OP_CONTAIN = 1'b0;
	localparam logic OP_OVERLAP = 1'b1;

	// register indexes (word address)
	localparam logic [2:0] REG_SHAPE_KIND  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_X    = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd2;
	localparam logic [2:0] REG_OBST_WIDTH  = 3'd3;
	localparam logic [2:0] REG_OBST_HEIGHT = 3'd4;

	// reset values of the box size
	localparam int unsigned OBST_SIZE_RESET = 16;

	// decision flags carried with a request down the pipeline
	typedef struct packed {
		logic use_dist;
		logic strict;
		logic pair_b;
		logic contain;
		logic gap;
	} hit_flags_t;

endpackage

@@ hw/rtl/obstacle_point_and_circle_hit_test_unit.sv @@
// obstacle point and circle hit test unit: config registers and hit pipeline
// throughput: one request per cycle, set by the four-stage pipeline
// (input register, clamped deltas, squares, compare into the result register)
// reset: pipeline emptied, obstacle set to a 16 by 16 wall at origin (0, 0)
// busy stays low since the result side never stalls
`include "assert_macros.svh"

module obstacle_point_and_circle_hit_test_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request side
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic [COORD_BITS-3:0] probe_radius,
	// result side
	output logic                  done,
	output logic                  hit,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import obhit_pkg::*;

	localparam int CB   = COORD_BITS;
	localparam int DW   = CB + 5;      // signed scaled delta
	localparam int MW   = CB + 4;      // delta magnitude
	localparam int SQW  = 2 * MW;      // squared magnitude
	localparam int RW   = CB + 2;      // radius
	localparam int RRW  = 2 * RW;      // squared radius
	localparam int CW   = SQW + 1;     // distance sum
	localparam int GW   = CB + 8;      // gap test scale

	// configuration registers
	shape_kind_t            shape_kind_q;
	logic signed [CB-1:0]   origin_x_q;
	logic signed [CB-1:0]   origin_y_q;
	logic [CB-2:0]          obst_width_q;
	logic [CB-2:0]          obst_height_q;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_kind_q  <= SHAPE_WALL;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			obst_width_q  <= (CB-1)'(OBST_SIZE_RESET);
			obst_height_q <= (CB-1)'(OBST_SIZE_RESET);
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_SHAPE_KIND:  shape_kind_q  <= shape_kind_t'(pwdata[1:0]);
				REG_ORIGIN_X:    origin_x_q    <= $signed(pwdata[CB-1:0]);
				REG_ORIGIN_Y:    origin_y_q    <= $signed(pwdata[CB-1:0]);
				REG_OBST_WIDTH:  obst_width_q  <= pwdata[CB-2:0];
				REG_OBST_HEIGHT: obst_height_q <= pwdata[CB-2:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[4:2])
			REG_SHAPE_KIND:  prdata = 32'(shape_kind_q);
			REG_ORIGIN_X:    prdata = 32'(origin_x_q);
			REG_ORIGIN_Y:    prdata = 32'(origin_y_q);
			REG_OBST_WIDTH:  prdata = 32'(obst_width_q);
			REG_OBST_HEIGHT: prdata = 32'(obst_height_q);
			default:         prdata = '0;
		endcase
	end

	// stage 1: request register
	logic                 v_s1;
	logic                 op_s1;
	logic signed [CB-1:0] px_s1;
	logic signed [CB-1:0] py_s1;
	logic [CB-3:0]        r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1 <= operation;
			px_s1 <= $signed(point_x);
			py_s1 <= $signed(point_y);
			r_s1  <= probe_radius;
		end
	end

	// distance from v to the interval [lo, hi], zero inside
	function automatic logic [MW-1:0] dist_1d(input logic signed [DW-1:0] v,
			input logic signed [DW-1:0] lo, input logic signed [DW-1:0] hi);
		logic signed [DW-1:0] d;
		if (v < lo)
			d = lo - v;
		else if (v > hi)
			d = v - hi;
		else
			d = '0;
		return d[MW-1:0];
	endfunction

	// stage 2 logic: offsets, scaled bounds and containment
	logic signed [DW-1:0] rx_e, ry_e, sx, sy, w_e, h_e;
	logic signed [DW-1:0] w3, w10, h7, h10;
	logic signed [GW-1:0] rx_g, s100, w_g;
	logic                 box_in, vert_in, horz_in, gap_hit;
	logic [CB-2:0]        side_min;
	logic [MW-1:0]        ax_d, ay_d, bx_d, by_d;
	logic [RW-1:0]        rad_d;
	hit_flags_t           flags_d;

	assign rx_e = DW'(px_s1) - DW'(origin_x_q);
	assign ry_e = DW'(py_s1) - DW'(origin_y_q);
	assign w_e  = $signed(DW'(obst_width_q));
	assign h_e  = $signed(DW'(obst_height_q));
	assign sx   = rx_e * DW'(10);
	assign sy   = ry_e * DW'(10);
	assign w3   = w_e * DW'(3);
	assign w10  = w_e * DW'(10);
	assign h7   = h_e * DW'(7);
	assign h10  = h_e * DW'(10);

	assign box_in  = (rx_e >= 0) && (rx_e <= w_e) && (ry_e >= 0) && (ry_e <= h_e);
	assign vert_in = (rx_e >= 0) && (sx <= w3) && (ry_e >= 0) && (ry_e <= h_e);
	assign horz_in = (rx_e >= 0) && (rx_e <= w_e) && (sy >= h7) && (ry_e <= h_e);

	// corridor gaps as cross-multiplied strict bounds
	assign rx_g    = GW'(px_s1) - GW'(origin_x_q);
	assign s100    = rx_g * GW'(100);
	assign w_g     = $signed(GW'(obst_width_q));
	assign gap_hit = ((s100 > w_g * GW'(35)) && (s100 < w_g * GW'(45))) ||
		((s100 > w_g * GW'(55)) && (s100 < w_g * GW'(65)));

	assign side_min = (obst_width_q < obst_height_q) ? obst_width_q : obst_height_q;

	// per-shape selection of distances, radius and flags
	always_comb begin
		ax_d    = '0;
		ay_d    = '0;
		bx_d    = '0;
		by_d    = '0;
		rad_d   = RW'(r_s1);
		flags_d = '0;
		unique case (shape_kind_q)
			SHAPE_CIRCLE: begin
				ax_d             = dist_1d((rx_e <<< 1) - w_e, '0, '0);
				ay_d             = dist_1d((ry_e <<< 1) - h_e, '0, '0);
				rad_d            = RW'(side_min) +
					((op_s1 == OP_OVERLAP) ? (RW'(r_s1) << 1) : '0);
				flags_d.use_dist = 1'b1;
			end
			SHAPE_L: begin
				ax_d             = dist_1d(sx, '0, w3);
				ay_d             = dist_1d(sy, '0, h10);
				bx_d             = dist_1d(sx, '0, w10);
				by_d             = dist_1d(sy, h7, h10);
				rad_d            = RW'(r_s1) * RW'(10);
				flags_d.use_dist = (op_s1 == OP_OVERLAP);
				flags_d.pair_b   = (op_s1 == OP_OVERLAP);
				flags_d.contain  = vert_in || horz_in;
			end
			SHAPE_CORRIDOR: begin
				ax_d             = dist_1d(rx_e, '0, w_e);
				ay_d             = dist_1d(ry_e, '0, h_e);
				flags_d.use_dist = (op_s1 == OP_OVERLAP);
				flags_d.contain  = box_in;
				flags_d.gap      = gap_hit;
			end
			default: begin
				ax_d             = dist_1d(rx_e, '0, w_e);
				ay_d             = dist_1d(ry_e, '0, h_e);
				flags_d.use_dist = (op_s1 == OP_OVERLAP);
				flags_d.strict   = 1'b1;
				flags_d.contain  = box_in;
			end
		endcase
	end

	// stage 2 registers
	logic          v_s2;
	logic [MW-1:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic [RW-1:0] rad_s2;
	hit_flags_t    flags_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s2    <= ax_d;
		ay_s2    <= ay_d;
		bx_s2    <= bx_d;
		by_s2    <= by_d;
		rad_s2   <= rad_d;
		flags_s2 <= flags_d;
	end

	// stage 3: squares
	logic           v_s3;
	logic [SQW-1:0] sax_s3, say_s3, sbx_s3, sby_s3;
	logic [RRW-1:0] rr_s3;
	hit_flags_t     flags_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sax_s3   <= SQW'(ax_s2) * SQW'(ax_s2);
		say_s3   <= SQW'(ay_s2) * SQW'(ay_s2);
		sbx_s3   <= SQW'(bx_s2) * SQW'(bx_s2);
		sby_s3   <= SQW'(by_s2) * SQW'(by_s2);
		rr_s3    <= RRW'(rad_s2) * RRW'(rad_s2);
		flags_s3 <= flags_s2;
	end

	// stage 4 logic: sums against the squared radius
	logic [CW-1:0] da, db, rr_c;
	logic          near_a, near_b, hit_d;

	assign da     = CW'(sax_s3) + CW'(say_s3);
	assign db     = CW'(sbx_s3) + CW'(sby_s3);
	assign rr_c   = CW'(rr_s3);
	assign near_a = flags_s3.strict ? (da < rr_c) : (da <= rr_c);
	assign near_b = flags_s3.pair_b && (db <= rr_c);
	assign hit_d  = (flags_s3.use_dist ? (near_a || near_b) : flags_s3.contain) &&
		!flags_s3.gap;

	// result register
	logic done_q, hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= hit_d;
	end

	assign done = done_q;
	assign hit  = hit_q;

	// checks
	`ASSERT_AT(a_req_to_done, clk, arst_n, (start && !busy) |-> ##4 done)
	`ASSERT_AT(a_done_from_req, clk, arst_n, done |-> $past(start && !busy, 4))
	`ASSERT_NEVER(a_strict_pair_b, clk, arst_n, flags_s2.strict && flags_s2.pair_b)
	`ASSERT_NEVER(a_gap_flags, clk, arst_n, flags_s2.gap && (flags_s2.strict || flags_s2.pair_b))

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the obstacle point and circle hit test unit
`timescale 1ns / 100ps

module tb;
	import obhit_pkg::*;

	localparam int COORD = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PHASES = 40;
	localparam int PROBES_PER_PHASE = 40;

	// one query request as presented on the request side
	typedef struct packed {
		logic        op;
		logic [15:0] x;
		logic [15:0] y;
		logic [13:0] r;
	} probe_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = OP_CONTAIN;
	logic [15:0] point_x = '0;
	logic [15:0] point_y = '0;
	logic [13:0] probe_radius = '0;
	logic        done;
	logic        hit;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// local copy of the obstacle registers
	shape_kind_t        obst_shape = SHAPE_WALL;
	logic signed [15:0] obst_ox = '0;
	logic signed [15:0] obst_oy = '0;
	logic [14:0]        obst_w = 15'(OBST_SIZE_RESET);
	logic [14:0]        obst_h = 15'(OBST_SIZE_RESET);

	probe_req_t pending_probes[$];
	logic       expected_hits[$];
	int         send_idle_pct = 34;
	int         failures = 0;
	int         quiet_cycles = 0;

	obstacle_point_and_circle_hit_test_unit #(
		.COORD_BITS(COORD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.point_x(point_x),
		.point_y(point_y),
		.probe_radius(probe_radius),
		.done(done),
		.hit(hit),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// squared distance from a point to a box against rad squared
	function automatic bit box_reach(longint px, longint py, longint x0, longint x1,
			longint y0, longint y1, longint rad, bit strict);
		longint dx, dy, d2;
		dx = px - clamp_to(px, x0, x1);
		dy = py - clamp_to(py, y0, y1);
		d2 = dx * dx + dy * dy;
		return strict ? (d2 < rad * rad) : (d2 <= rad * rad);
	endfunction

	// expected hit flag for one request under the current obstacle
	function automatic logic predict_hit(probe_req_t q);
		longint px, py, rx, ry, w, h, r, dmin, dx, dy, rad, s;
		bit     ovl, hv, gap;
		ovl = (q.op == OP_OVERLAP);
		px = longint'($signed(q.x));
		py = longint'($signed(q.y));
		r = longint'(q.r);
		w = longint'(obst_w);
		h = longint'(obst_h);
		rx = px - longint'(obst_ox);
		ry = py - longint'(obst_oy);
		case (obst_shape)
			SHAPE_CIRCLE: begin
				// doubled coordinates keep the centre on the integer grid
				dmin = (w < h) ? w : h;
				dx = 2 * rx - w;
				dy = 2 * ry - h;
				rad = dmin + (ovl ? 2 * r : 64'sd0);
				hv = (dx * dx + dy * dy) <= rad * rad;
			end
			SHAPE_L: begin
				// tenfold scale for the 0.3 and 0.7 splits
				if (ovl)
					hv = box_reach(10 * rx, 10 * ry, 0, 3 * w, 0, 10 * h, 10 * r, 1'b0) ||
						box_reach(10 * rx, 10 * ry, 0, 10 * w, 7 * h, 10 * h, 10 * r, 1'b0);
				else
					hv = (rx >= 0 && 10 * rx <= 3 * w && ry >= 0 && ry <= h) ||
						(rx >= 0 && rx <= w && 10 * ry >= 7 * h && ry <= h);
			end
			SHAPE_CORRIDOR: begin
				if (ovl)
					hv = box_reach(rx, ry, 0, w, 0, h, r, 1'b0);
				else
					hv = rx >= 0 && rx <= w && ry >= 0 && ry <= h;
				// open gaps, hundredfold scale, strict edges
				s = 100 * rx;
				gap = (s > 35 * w && s < 45 * w) || (s > 55 * w && s < 65 * w);
				hv = hv && !gap;
			end
			default: begin
				if (ovl)
					hv = box_reach(rx, ry, 0, w, 0, h, r, 1'b1);
				else
					hv = rx >= 0 && rx <= w && ry >= 0 && ry <= h;
			end
		endcase
		return hv;
	endfunction

	// request driver: presents queued requests with random gaps
	always @(posedge clk) begin : drive_probes
		probe_req_t nxt;
		if (arst_n) begin
			if (start && !busy)
				expected_hits.push_back(predict_hit(probe_req_t'{operation, point_x, point_y,
					probe_radius}));
			if (!start || !busy) begin
				if (pending_probes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_probes.pop_front();
					start <= 1'b1;
					operation <= nxt.op;
					point_x <= nxt.x;
					point_y <= nxt.y;
					probe_radius <= nxt.r;
				end else begin
					// junk on the payload while idle
					start <= 1'b0;
					operation <= 1'($urandom);
					point_x <= 16'($urandom);
					point_y <= 16'($urandom);
					probe_radius <= 14'($urandom);
				end
			end
		end
	end

	// result monitor: compares each strobed hit with the oldest prediction
	always @(posedge clk) begin : check_hits
		logic want;
		if (arst_n && done === 1'b1) begin
			if (expected_hits.size() == 0) begin
				$display("%0t unexpected result: expected none actual hit %0b", $time, hit);
				failures++;
			end else begin
				want = expected_hits.pop_front();
				if (hit !== want) begin
					$display("%0t hit mismatch: expected %0b actual %0b", $time, want, hit);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles with no request and no result accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done === 1'b1)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL obstacle_point_and_circle_hit_test_unit");
				$finish;
			end
		end
	end

	task automatic queue_probe(logic op, logic [15:0] x, logic [15:0] y, logic [13:0] r);
		pending_probes.push_back(probe_req_t'{op, x, y, r});
	endtask

	// wait until every request has gone in and every result has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_probes.size() != 0 || start || expected_hits.size() != 0)
			@(negedge clk);
	endtask

	// apb write: setup then access, register taken when pready is high
	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SHAPE_KIND:  obst_shape = shape_kind_t'(val[1:0]);
			REG_ORIGIN_X:    obst_ox = val[15:0];
			REG_ORIGIN_Y:    obst_oy = val[15:0];
			REG_OBST_WIDTH:  obst_w = val[14:0];
			REG_OBST_HEIGHT: obst_h = val[14:0];
			default: ;
		endcase
	endtask

	// write all obstacle registers, with junk in the unused upper bits
	task automatic load_obstacle(shape_kind_t shape, logic [15:0] ox, logic [15:0] oy,
			logic [14:0] w, logic [14:0] h);
		logic [31:0] v;
		v = $urandom;
		v[1:0] = shape;
		apb_write(REG_SHAPE_KIND, v);
		v = $urandom;
		v[15:0] = ox;
		apb_write(REG_ORIGIN_X, v);
		v = $urandom;
		v[15:0] = oy;
		apb_write(REG_ORIGIN_Y, v);
		v = $urandom;
		v[14:0] = w;
		apb_write(REG_OBST_WIDTH, v);
		v = $urandom;
		v[14:0] = h;
		apb_write(REG_OBST_HEIGHT, v);
	endtask

	// stimulus
	initial begin
		int          p, k, margin;
		logic [15:0] ox, oy, x, y;
		logic [14:0] w, h;
		logic [13:0] r;
		logic        op;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset obstacle: 16 by 16 wall at the origin, edges and extremes
		queue_probe(OP_CONTAIN, 16'd0, 16'd0, 14'd0);
		queue_probe(OP_CONTAIN, 16'd16, 16'd16, 14'd0);
		queue_probe(OP_CONTAIN, 16'd17, 16'd8, 14'd0);
		queue_probe(OP_CONTAIN, 16'd8, -16'sd1, 14'd0);
		queue_probe(OP_CONTAIN, 16'h8000, 16'h8000, 14'h3fff);
		queue_probe(OP_CONTAIN, 16'h7fff, 16'h7fff, 14'd0);
		// zero probe radius never hits a wall, touching distance is strict
		queue_probe(OP_OVERLAP, 16'd8, 16'd8, 14'd0);
		queue_probe(OP_OVERLAP, -16'sd1, 16'd8, 14'd1);
		queue_probe(OP_OVERLAP, -16'sd1, 16'd8, 14'd2);
		queue_probe(OP_OVERLAP, 16'h8000, 16'h7fff, 14'h3fff);
		wait_drained();

		// corridor gap edges, plus a write to an unused register index
		load_obstacle(SHAPE_CORRIDOR, 16'd0, 16'd0, 15'd100, 15'd50);
		apb_write(REG_OBST_HEIGHT + 3'd1, $urandom);
		queue_probe(OP_CONTAIN, 16'd35, 16'd10, 14'd0);
		queue_probe(OP_CONTAIN, 16'd36, 16'd10, 14'd0);
		queue_probe(OP_CONTAIN, 16'd45, 16'd10, 14'd0);
		queue_probe(OP_CONTAIN, 16'd50, 16'd10, 14'd0);
		queue_probe(OP_CONTAIN, 16'd60, 16'd10, 14'd0);
		queue_probe(OP_CONTAIN, 16'd65, 16'd10, 14'd0);
		queue_probe(OP_OVERLAP, 16'd40, 16'd60, 14'h3fff);
		queue_probe(OP_OVERLAP, 16'd50, 16'd60, 14'd10);
		wait_drained();

		// circle boundary and touching probe
		load_obstacle(SHAPE_CIRCLE, 16'd100, 16'd100, 15'd40, 15'd20);
		queue_probe(OP_CONTAIN, 16'd120, 16'd110, 14'd0);
		queue_probe(OP_CONTAIN, 16'd130, 16'd110, 14'd0);
		queue_probe(OP_OVERLAP, 16'd135, 16'd110, 14'd3);
		queue_probe(OP_OVERLAP, 16'd135, 16'd110, 14'd5);
		wait_drained();

		// l shape bar edges
		load_obstacle(SHAPE_L, 16'd0, 16'd0, 15'd100, 15'd100);
		queue_probe(OP_CONTAIN, 16'd30, 16'd10, 14'd0);
		queue_probe(OP_CONTAIN, 16'd31, 16'd10, 14'd0);
		queue_probe(OP_CONTAIN, 16'd50, 16'd70, 14'd0);

		// random phases, each under a fresh obstacle
		for (p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			ox = 16'($urandom);
			oy = 16'($urandom);
			w = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(1, 200));
			h = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(1, 200));
			case (p % 8)
				0: begin
					ox = 16'h8000;
					oy = 16'h8000;
					w = 15'h7fff;
					h = 15'h7fff;
				end
				1: begin
					ox = 16'h7fff;
					oy = 16'h7fff;
					w = 15'd1;
					h = 15'd1;
				end
				2: w = '0;
				3: h = '0;
				default: ;
			endcase
			load_obstacle(shape_kind_t'((p + p / 8) % 4), ox, oy, w, h);

			// sender gaps heavy, then heavier, then none
			if (p < RANDOM_PHASES / 3)
				send_idle_pct = 34;
			else if (p < 2 * RANDOM_PHASES / 3)
				send_idle_pct = 52;
			else
				send_idle_pct = 0;

			margin = (int'(w) + int'(h)) / 4 + 8;
			for (k = 0; k < PROBES_PER_PHASE; k++) begin
				if ($urandom_range(0, 7) == 0) begin
					op = 1'($urandom);
					x = 16'($urandom);
					y = 16'($urandom);
					r = 14'($urandom);
				end else begin
					// points scattered round the box so both outcomes occur
					op = 1'($urandom);
					x = 16'(int'(obst_ox) - margin +
						int'($urandom_range(0, int'(w) + 2 * margin)));
					y = 16'(int'(obst_oy) - margin +
						int'($urandom_range(0, int'(h) + 2 * margin)));
					r = ($urandom_range(0, 9) == 0) ? 14'($urandom) :
						14'($urandom_range(0, margin));
				end
				queue_probe(op, x, y, r);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("PASS obstacle_point_and_circle_hit_test_unit");
		else
			$display("FAIL obstacle_point_and_circle_hit_test_unit");
		$finish;
	end

endmodule
